>>> sv/svt_pkg.sv
// Shared widths, register codes and reset values for the smoothstep velocity tracker.
`timescale 1ns / 1ps

package svt_pkg;

	// Default fixed-point layout
	localparam int FRAC_BITS_DEF    = 16;
	localparam int UNWRAP_WIDTH_DEF = 40;

	// Field widths
	localparam int TICK_W    = 16;
	localparam int SWEEP_W   = 21;
	localparam int FFS_W     = 23;
	localparam int GAIN_W    = 20;
	localparam int VLIM_W    = 22;
	localparam int HALF_W    = 20;
	localparam int PLIM_W    = 20;
	localparam int MEAS_W    = 21;
	localparam int VEL_W     = 23;
	localparam int ERR_W     = 40;
	localparam int CFG_W     = 23;
	localparam int CFG_IDX_W = 3;

	// Internal widths that follow from the field ranges
	localparam int ERR_SPLIT = 20;   // low half of the error used as an unsigned partial operand
	localparam int PROG_W    = 22;   // sweep progress, |s*sweep| / 2^F <= 2^20
	localparam int FF_W      = 24;   // feedforward before sign, |d*ffs| / 2^F < 1.5 * 2^22
	localparam int ACC_W     = GAIN_W + ERR_W + 1;
	localparam int X_W       = MEAS_W + 2;   // measurement step plus half range

	// Register file codes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DURATION,
		CFG_SWEEP,
		CFG_FF_SCALE,
		CFG_REVERSE,
		CFG_GAIN,
		CFG_VEL_LIMIT,
		CFG_WRAP_HALF,
		CFG_POS_LIMIT
	} cfg_reg_t;

	// Request kinds
	typedef enum logic {
		REQ_START,
		REQ_TICK
	} req_t;

	// Register reset values
	localparam logic [TICK_W-1:0]  DUR_RST   = 16'd500;
	localparam logic [SWEEP_W-1:0] SWEEP_RST = 21'd411775;
	localparam logic [FFS_W-1:0]   FFS_RST   = 23'd82355;
	localparam logic               REV_RST   = 1'b0;
	localparam logic [GAIN_W-1:0]  GAIN_RST  = 20'd131072;
	localparam logic [VLIM_W-1:0]  VLIM_RST  = 22'd655360;
	localparam logic [HALF_W-1:0]  HALF_RST  = 20'd819200;
	localparam logic [PLIM_W-1:0]  PLIM_RST  = 20'd819200;

	localparam logic [TICK_W-1:0]  TICK_SAT  = '1;

endpackage

>>> sv/svt_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module svt_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 21
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot,
	output logic [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   trial_sub;
	logic             fits;

	// Bring down the next dividend bit and try the subtract
	always_comb begin
		trial     = {rem_q, num_q[NUM_W-1]};
		trial_sub = trial - {1'b0, den_q};
		fits      = trial >= {1'b0, den_q};
	end

	// Count iterations and flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift quotient bits in as the dividend shifts out
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;
	assign rem  = rem_q;

endmodule

>>> sv/smoothstep_velocity_tracker_unwrap.sv
// Top level of the smoothstep phase-sweep velocity tracker with position unwrap.
`timescale 1ns / 1ps
//
// Usage: configure the eight registers through cfg_write / cfg_index / cfg_data
// while the block is idle. Requests arrive on in_valid / in_stall with req_type
// and measured_position. A start request (req_type 0) reloads the unwrapper and
// the start position and produces no result; the block stays idle. A tick
// request (req_type 1) produces exactly one result on out_valid / out_stall.
// A tick while running uses the shared divider for the wrap remainder when the
// half range is nonzero and for u while the sweep is not done, one quotient bit
// per cycle, then nine steps reuse a single multiplier. A tick while idle goes
// straight to the emit state. One request is processed at a time;
// in_stall is high from acceptance until the result is loaded into the
// output register, which holds it while out_stall is high. The next request
// may be accepted while a result still waits there. Reset clears the tracker
// state, loads the register defaults and leaves no result pending.
//
module smoothstep_velocity_tracker_unwrap
	import svt_pkg::*;
#(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int UNWRAP_WIDTH = UNWRAP_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration write port
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	// request channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     req_type,
	input  logic signed [MEAS_W-1:0] measured_position,
	// result channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [VEL_W-1:0]  velocity_command,
	output logic signed [MEAS_W-1:0] position_command,
	output logic signed [ERR_W-1:0]  tracking_error,
	output logic                     phase_done
);

	localparam int W      = UNWRAP_WIDTH;
	localparam int MW     = (FRAC_BITS + 3 > FFS_W) ? FRAC_BITS + 3 : FFS_W;
	localparam int PW     = 2 * MW;
	localparam int NUM_W  = (TICK_W + FRAC_BITS > MEAS_W + 1) ? TICK_W + FRAC_BITS : MEAS_W + 1;
	localparam int DEN_W  = HALF_W + 1;
	localparam int ERRX_W = (W > ERR_W) ? W : ERR_W;
	localparam int SUM_W  = ACC_W + 1;
	localparam int POS_W  = MEAS_W + 1;

	localparam logic [FRAC_BITS:0] ONE_U = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [MW-1:0]      ONE_M = {{(MW-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic signed [ERRX_W-1:0] ERR_HI = ERRX_W'({1'b0, {(ERR_W-1){1'b1}}});
	localparam logic signed [ERRX_W-1:0] ERR_LO = ~ERR_HI;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIFF,
		S_WRAP_DIV,
		S_UNWRAP,
		S_U_DIV,
		S_M1,
		S_M2,
		S_M3,
		S_M4,
		S_M5,
		S_ERR,
		S_FBL,
		S_FBH,
		S_ACC,
		S_VEL,
		S_EMIT
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [TICK_W-1:0]         dur_q;
	logic signed [SWEEP_W-1:0] sweep_q;
	logic signed [FFS_W-1:0]   ffs_q;
	logic                      rev_q;
	logic [GAIN_W-1:0]         gain_q;
	logic [VLIM_W-1:0]         vlim_q;
	logic [HALF_W-1:0]         half_q;
	logic [PLIM_W-1:0]         plim_q;

	// Tracker state
	logic [W-1:0]              unw_q;
	logic signed [MEAS_W-1:0]  prev_q;
	logic [W-1:0]              start_q;
	logic [TICK_W-1:0]         tick_q;
	logic                      running_q;
	logic                      out_valid_q;

	// Working registers
	logic signed [MEAS_W-1:0]  meas_q;
	logic                      done_q;
	logic signed [X_W-1:0]     x_q;
	logic [FRAC_BITS:0]        u_q;
	logic [FRAC_BITS:0]        u2_q;
	logic [FRAC_BITS:0]        d_q;
	logic [FRAC_BITS:0]        s_q;
	logic signed [FF_W-1:0]    ff_q;
	logic [ERR_W-1:0]          err_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [VEL_W-1:0]   vel_q;
	logic signed [PW-1:0]      prod_q;

	// Output register
	logic signed [VEL_W-1:0]   vel_out_q;
	logic signed [MEAS_W-1:0]  pos_out_q;
	logic [ERR_W-1:0]          err_out_q;
	logic                      done_out_q;

	// Combinational datapath
	logic [TICK_W-1:0]         dur_eff;
	logic                      done_c;
	logic                      emit_load;
	logic signed [X_W-1:0]     x_c;
	logic [MEAS_W:0]           absx_c;
	logic [DEN_W-1:0]          period_c;
	logic signed [X_W-1:0]     r_c;
	logic signed [X_W-1:0]     wdiff_c;
	logic [MW-1:0]             u_m;
	logic [MW-1:0]             one_u;
	logic [MW-1:0]             three_u;
	logic signed [MW-1:0]      mul_a;
	logic signed [MW-1:0]      mul_b;
	logic signed [PW-1:0]      prod_c;
	logic signed [PW-1:0]      p6_c;
	logic signed [PROG_W-1:0]  prog_c;
	logic signed [PROG_W:0]    sprog_c;
	logic [W-1:0]              des_c;
	logic [W-1:0]              errw_c;
	logic signed [ERRX_W-1:0]  errs_c;
	logic signed [ERRX_W-1:0]  err_sat_c;
	logic signed [ACC_W-1:0]   fb_c;
	logic signed [ACC_W-1:0]   ffx_c;
	logic signed [ACC_W-1:0]   ffv_c;
	logic signed [SUM_W-1:0]   sum_c;
	logic signed [SUM_W-1:0]   vl_c;
	logic signed [SUM_W-1:0]   vel_c;
	logic signed [POS_W-1:0]   mx_c;
	logic signed [POS_W-1:0]   pl_c;
	logic signed [POS_W-1:0]   pos_c;

	// Divider hookup
	logic                      div_start;
	logic [NUM_W-1:0]          div_num;
	logic [DEN_W-1:0]          div_den;
	logic                      div_done;
	logic [NUM_W-1:0]          div_quot;
	logic [DEN_W-1:0]          div_rem;

	assign in_stall  = (state_q != S_IDLE);
	assign emit_load = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign dur_eff   = (dur_q == '0) ? TICK_W'(1) : dur_q;
	assign done_c    = tick_q >= dur_eff;

	// Unwrap: step, its magnitude for the remainder, and the folded step
	always_comb begin
		x_c      = X_W'(meas_q) - X_W'(prev_q) + X_W'(half_q);
		absx_c   = x_c[X_W-1] ? (MEAS_W+1)'(-x_c) : (MEAS_W+1)'(x_c);
		period_c = {half_q, 1'b0};
		if (half_q == '0) begin
			r_c = x_q;
		end else if (x_q[X_W-1] && (div_rem != '0)) begin
			r_c = X_W'(period_c) - X_W'(div_rem);
		end else begin
			r_c = X_W'(div_rem);
		end
		wdiff_c = r_c - X_W'(half_q);
	end

	// Divider operands: wrap remainder first, then u
	always_comb begin
		div_start = ((state_q == S_DIFF) && (half_q != '0)) ||
		            ((state_q == S_UNWRAP) && !done_q);
		if (state_q == S_DIFF) begin
			div_num = NUM_W'(absx_c);
			div_den = period_c;
		end else begin
			div_num = NUM_W'({tick_q, {FRAC_BITS{1'b0}}});
			div_den = DEN_W'(dur_eff);
		end
	end

	svt_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot),
		.rem   (div_rem)
	);

	// Select multiplier operands for the current step
	always_comb begin
		u_m     = MW'(u_q);
		one_u   = ONE_M - u_m;
		three_u = ONE_M + (ONE_M << 1) - (u_m << 1);
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			S_M1: begin
				mul_a = signed'(u_m);
				mul_b = signed'(u_m);
			end
			S_M2: begin
				mul_a = signed'(u_m);
				mul_b = signed'(one_u);
			end
			S_M3: begin
				mul_a = signed'(MW'(u2_q));
				mul_b = signed'(three_u);
			end
			S_M4: begin
				mul_a = signed'(MW'(d_q));
				mul_b = MW'(ffs_q);
			end
			S_M5: begin
				mul_a = signed'(MW'(s_q));
				mul_b = MW'(sweep_q);
			end
			S_FBL: begin
				mul_a = signed'(MW'(gain_q));
				mul_b = signed'(MW'(err_q[ERR_SPLIT-1:0]));
			end
			S_FBH: begin
				mul_a = signed'(MW'(gain_q));
				mul_b = MW'(signed'(err_q[ERR_W-1:ERR_SPLIT]));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod_c = mul_a * mul_b;
		p6_c   = (prod_q <<< 2) + (prod_q <<< 1);
	end

	// Desired position and saturated tracking error
	always_comb begin
		prog_c  = prod_q[FRAC_BITS +: PROG_W];
		sprog_c = rev_q ? -((PROG_W+1)'(prog_c)) : (PROG_W+1)'(prog_c);
		des_c   = start_q + W'(sprog_c);
		errw_c  = des_c - unw_q;
		errs_c  = ERRX_W'(signed'(errw_c));
		if (errs_c > ERR_HI) begin
			err_sat_c = ERR_HI;
		end else if (errs_c < ERR_LO) begin
			err_sat_c = ERR_LO;
		end else begin
			err_sat_c = errs_c;
		end
	end

	// Feedforward plus feedback, clamped to the velocity limit
	always_comb begin
		fb_c  = acc_q >>> FRAC_BITS;
		ffx_c = ACC_W'(ff_q);
		ffv_c = rev_q ? -ffx_c : ffx_c;
		sum_c = SUM_W'(fb_c) + SUM_W'(ffv_c);
		vl_c  = SUM_W'(vlim_q);
		if (sum_c > vl_c) begin
			vel_c = vl_c;
		end else if (sum_c < -vl_c) begin
			vel_c = -vl_c;
		end else begin
			vel_c = sum_c;
		end
	end

	// Position command: clamp the raw measurement
	always_comb begin
		mx_c = POS_W'(meas_q);
		pl_c = POS_W'(plim_q);
		if (mx_c > pl_c) begin
			pos_c = pl_c;
		end else if (mx_c < -pl_c) begin
			pos_c = -pl_c;
		end else begin
			pos_c = mx_c;
		end
	end

	// Sequencer, configuration and tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dur_q       <= DUR_RST;
			sweep_q     <= SWEEP_RST;
			ffs_q       <= FFS_RST;
			rev_q       <= REV_RST;
			gain_q      <= GAIN_RST;
			vlim_q      <= VLIM_RST;
			half_q      <= HALF_RST;
			plim_q      <= PLIM_RST;
			unw_q       <= '0;
			prev_q      <= '0;
			start_q     <= '0;
			tick_q      <= '0;
			running_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// register writes
			if (cfg_write) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_DURATION:  dur_q   <= cfg_data[TICK_W-1:0];
					CFG_SWEEP:     sweep_q <= cfg_data[SWEEP_W-1:0];
					CFG_FF_SCALE:  ffs_q   <= cfg_data[FFS_W-1:0];
					CFG_REVERSE:   rev_q   <= cfg_data[0];
					CFG_GAIN:      gain_q  <= cfg_data[GAIN_W-1:0];
					CFG_VEL_LIMIT: vlim_q  <= cfg_data[VLIM_W-1:0];
					CFG_WRAP_HALF: half_q  <= cfg_data[HALF_W-1:0];
					CFG_POS_LIMIT: plim_q  <= cfg_data[PLIM_W-1:0];
					default: ;
				endcase
			end

			// hold the result until taken
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (req_t'(req_type) == REQ_START) begin
							unw_q     <= W'(measured_position);
							start_q   <= W'(measured_position);
							prev_q    <= measured_position;
							tick_q    <= '0;
							running_q <= 1'b1;
						end else begin
							state_q <= running_q ? S_DIFF : S_EMIT;
						end
					end
				end
				S_DIFF: begin
					state_q <= (half_q == '0) ? S_UNWRAP : S_WRAP_DIV;
				end
				S_WRAP_DIV: begin
					if (div_done) begin
						state_q <= S_UNWRAP;
					end
				end
				S_UNWRAP: begin
					unw_q   <= unw_q + W'(wdiff_c);
					prev_q  <= meas_q;
					state_q <= done_q ? S_M1 : S_U_DIV;
				end
				S_U_DIV: begin
					if (div_done) begin
						state_q <= S_M1;
					end
				end
				S_M1:  state_q <= S_M2;
				S_M2:  state_q <= S_M3;
				S_M3:  state_q <= S_M4;
				S_M4:  state_q <= S_M5;
				S_M5:  state_q <= S_ERR;
				S_ERR: state_q <= S_FBL;
				S_FBL: state_q <= S_FBH;
				S_FBH: state_q <= S_ACC;
				S_ACC: state_q <= S_VEL;
				S_VEL: begin
					// advance the tick count, drop running on the completing tick
					if (tick_q != TICK_SAT) begin
						tick_q <= tick_q + 1'b1;
					end
					if (done_q) begin
						running_q <= 1'b0;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= prod_c;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					meas_q <= measured_position;
					done_q <= done_c;
					vel_q  <= '0;
					err_q  <= '0;
				end
			end
			S_DIFF: x_q <= x_c;
			S_UNWRAP: begin
				if (done_q) begin
					u_q <= ONE_U;
				end
			end
			S_U_DIV: begin
				if (div_done) begin
					u_q <= (FRAC_BITS+1)'(div_quot[FRAC_BITS-1:0]);
				end
			end
			S_M2:  u2_q <= prod_q[FRAC_BITS +: FRAC_BITS+1];
			S_M3:  d_q  <= p6_c[FRAC_BITS +: FRAC_BITS+1];
			S_M4:  s_q  <= prod_q[FRAC_BITS +: FRAC_BITS+1];
			S_M5:  ff_q <= prod_q[FRAC_BITS +: FF_W];
			S_ERR: err_q <= ERR_W'(err_sat_c);
			S_FBH: acc_q <= ACC_W'(prod_q);
			S_ACC: acc_q <= acc_q + (ACC_W'(prod_q) <<< ERR_SPLIT);
			S_VEL: vel_q <= VEL_W'(vel_c);
			S_EMIT: begin
				if (emit_load) begin
					vel_out_q  <= vel_q;
					pos_out_q  <= MEAS_W'(pos_c);
					err_out_q  <= err_q;
					done_out_q <= done_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid        = out_valid_q;
	assign velocity_command = vel_out_q;
	assign position_command = pos_out_q;
	assign tracking_error   = signed'(err_out_q);
	assign phase_done       = done_out_q;

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the smoothstep velocity tracker with position unwrap.
`timescale 1ns / 1ps

module tb_top;
	import svt_pkg::*;

	localparam int FRAC       = FRAC_BITS_DEF;
	localparam int UW         = UNWRAP_WIDTH_DEF;
	localparam int MEAS_SPAN  = 819200;
	localparam int RAND_ITEMS = 650;
	localparam int CALM_FROM  = 240;
	localparam int CALM_TO    = 360;
	localparam int SETTLE     = 8;
	localparam int TAIL       = 200;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic signed [VEL_W-1:0]  vel;
		logic signed [MEAS_W-1:0] pos;
		logic signed [ERR_W-1:0]  err;
		logic                     done;
	} motion_t;

	typedef enum {ROW_WRITE, ROW_REQ} row_kind_t;

	typedef struct {
		row_kind_t kind;
		cfg_reg_t  idx;
		int        data;
		req_t      req;
		int        meas;
		bit        typed;
		motion_t   want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = 1'b0;
	logic signed [MEAS_W-1:0] measured_position = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [VEL_W-1:0] velocity_command;
	logic signed [MEAS_W-1:0] position_command;
	logic signed [ERR_W-1:0] tracking_error;
	logic phase_done;

	// Register shadow
	logic [TICK_W-1:0]         dur_r   = DUR_RST;
	logic signed [SWEEP_W-1:0] sweep_r = SWEEP_RST;
	logic signed [FFS_W-1:0]   ffs_r   = FFS_RST;
	logic                      rev_r   = REV_RST;
	logic [GAIN_W-1:0]         gain_r  = GAIN_RST;
	logic [VLIM_W-1:0]         vlim_r  = VLIM_RST;
	logic [HALF_W-1:0]         half_r  = HALF_RST;
	logic [PLIM_W-1:0]         plim_r  = PLIM_RST;

	// Tracker state shadow
	logic [UW-1:0]            unw_pos = '0;
	logic [UW-1:0]            start_pos = '0;
	logic signed [MEAS_W-1:0] last_meas = '0;
	logic [TICK_W-1:0]        tick_cnt = '0;
	bit                       sweeping = 1'b0;

	motion_t     motion_q[$];
	plan_row_t   plan[$];
	int          mismatches = 0;
	int          sent = 0;
	bit          calm = 1'b0;
	int unsigned cycles = 0;

	smoothstep_velocity_tracker_unwrap u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.req_type          (req_type),
		.measured_position (measured_position),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.velocity_command  (velocity_command),
		.position_command  (position_command),
		.tracking_error    (tracking_error),
		.phase_done        (phase_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Advance the tracker shadow by one request and form the result it causes
	task automatic advance_tracker(input req_t kind, input logic signed [MEAS_W-1:0] meas,
			output bit emits, output motion_t res);
		longint one, dur, m, tc, diff, half, period, r, u, u2, s, d;
		longint prog, ff, fb, vel, err, sgn, lim;
		logic [UW-1:0] des;
		logic signed [UW-1:0] e40;
		logic signed [MEAS_W-1:0] prev;
		bit done;
		one = longint'(1) << FRAC;
		m = meas;
		emits = 1'b0;
		res = '0;
		if (kind == REQ_START) begin
			unw_pos = UW'(m);
			start_pos = UW'(m);
			last_meas = meas;
			tick_cnt = '0;
			sweeping = 1'b1;
		end else begin
			dur = (dur_r == 0) ? 1 : longint'(dur_r);
			tc = longint'(tick_cnt);
			done = (tc >= dur);
			vel = 0;
			err = 0;
			if (sweeping) begin
				prev = last_meas;
				diff = m - longint'(prev);
				half = longint'(half_r);
				// fold the step into the shortest one on the wrap period
				if (half > 0) begin
					period = 2 * half;
					r = (diff + half) % period;
					if (r < 0)
						r += period;
					diff = r - half;
				end
				unw_pos = unw_pos + UW'(diff);
				last_meas = meas;

				u = done ? one : ((tc << FRAC) / dur);
				u2 = (u * u) >>> FRAC;
				s = (u2 * (3 * one - 2 * u)) >>> FRAC;
				d = (6 * u * (one - u)) >>> FRAC;
				sgn = rev_r ? -1 : 1;
				prog = (s * longint'(sweep_r)) >>> FRAC;

				des = start_pos + UW'(sgn * prog);
				e40 = des - unw_pos;
				err = e40;

				ff = sgn * ((d * longint'(ffs_r)) >>> FRAC);
				fb = (longint'(gain_r) * err) >>> FRAC;
				vel = ff + fb;
				lim = longint'(vlim_r);
				if (vel > lim)
					vel = lim;
				else if (vel < -lim)
					vel = -lim;

				if (tick_cnt != TICK_SAT)
					tick_cnt = tick_cnt + 1'b1;
				if (done)
					sweeping = 1'b0;
			end
			lim = longint'(plim_r);
			if (m > lim)
				m = lim;
			else if (m < -lim)
				m = -lim;
			emits = 1'b1;
			res.vel = VEL_W'(vel);
			res.pos = MEAS_W'(m);
			res.err = ERR_W'(err);
			res.done = done;
		end
	endtask

	// Write one register and mirror it
	task automatic write_reg(cfg_reg_t idx, int value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		case (idx)
			CFG_DURATION:  dur_r = TICK_W'(value);
			CFG_SWEEP:     sweep_r = SWEEP_W'(value);
			CFG_FF_SCALE:  ffs_r = FFS_W'(value);
			CFG_REVERSE:   rev_r = value[0];
			CFG_GAIN:      gain_r = GAIN_W'(value);
			CFG_VEL_LIMIT: vlim_r = VLIM_W'(value);
			CFG_WRAP_HALF: half_r = HALF_W'(value);
			CFG_POS_LIMIT: plim_r = PLIM_W'(value);
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Offer one request, hold it until taken, then queue its expected result, if any
	task automatic send_req(req_t kind, int meas, bit typed, motion_t want);
		int gap;
		bit emits;
		motion_t got;
		calm = (sent >= CALM_FROM && sent < CALM_TO);
		gap = 0;
		if (!calm) begin
			while ($urandom_range(0, 99) < 26)
				gap++;
			if ($urandom_range(0, 39) == 0)
				gap += $urandom_range(20, 150);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		measured_position <= MEAS_W'(meas);
		do @(posedge clk); while (in_stall);
		advance_tracker(kind, MEAS_W'(meas), emits, got);
		if (emits)
			motion_q.push_back(typed ? want : got);
		sent++;
	endtask

	// Hold off until every expected result is back and the block is quiet
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (motion_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic plan_row_t cfg_row(cfg_reg_t idx, int value);
		plan_row_t r;
		r = '{kind: ROW_WRITE, idx: idx, data: value, req: REQ_START, meas: 0,
			typed: 1'b0, want: '0};
		return r;
	endfunction

	function automatic plan_row_t req_row(req_t kind, int meas);
		plan_row_t r;
		r = '{kind: ROW_REQ, idx: CFG_DURATION, data: 0, req: kind, meas: meas,
			typed: 1'b0, want: '0};
		return r;
	endfunction

	function automatic plan_row_t fixed_row(int meas, int vel, int pos, longint err, bit done);
		plan_row_t r;
		r = req_row(REQ_TICK, meas);
		r.typed = 1'b1;
		r.want.vel = VEL_W'(vel);
		r.want.pos = MEAS_W'(pos);
		r.want.err = ERR_W'(err);
		r.want.done = done;
		return r;
	endfunction

	function automatic int any_meas();
		return int'($urandom_range(0, 2 * MEAS_SPAN)) - MEAS_SPAN;
	endfunction

	// Move the reading by a step of up to a bit over the wrap half range, then wrap
	function automatic int walk_meas(int cur);
		int span, nxt;
		span = (half_r == 0) ? MEAS_SPAN : int'(half_r);
		span = span + span / 4;
		nxt = cur + int'($urandom_range(0, 2 * span)) - span;
		if (nxt > MEAS_SPAN)
			nxt -= 2 * MEAS_SPAN;
		else if (nxt < -MEAS_SPAN)
			nxt += 2 * MEAS_SPAN;
		return nxt;
	endfunction

	// Pick a value in range, hitting the ends now and then
	function automatic int pick(int lo, int hi);
		case ($urandom_range(0, 7))
			0: return lo;
			1: return hi;
			default: return lo + int'($urandom_range(0, hi - lo));
		endcase
	endfunction

	task automatic shuffle_settings();
		int dur;
		case ($urandom_range(0, 9))
			0: dur = 0;
			1: dur = 65535;
			2: dur = 1;
			default: dur = $urandom_range(2, 24);
		endcase
		write_reg(CFG_DURATION, dur);
		write_reg(CFG_SWEEP, pick(-823550, 823550));
		write_reg(CFG_FF_SCALE, pick(-3276800, 3276800));
		write_reg(CFG_REVERSE, $urandom_range(0, 1));
		write_reg(CFG_GAIN, pick(0, 1048575));
		write_reg(CFG_VEL_LIMIT, pick(0, 3276800));
		write_reg(CFG_WRAP_HALF, ($urandom_range(0, 7) == 0) ? 0 : pick(65536, 819200));
		write_reg(CFG_POS_LIMIT, pick(0, 819200));
	endtask

	// Check each result taken against the oldest expectation
	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		motion_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (motion_q.size() == 0) begin
				$display("%0t: result with none expected: vel %0d pos %0d err %0d done %0d",
					$time, velocity_command, position_command, tracking_error, phase_done);
				mismatches++;
			end else begin
				w = motion_q.pop_front();
				check_field("velocity_command", w.vel, velocity_command);
				check_field("position_command", w.pos, position_command);
				check_field("tracking_error", w.err, tracking_error);
				check_field("phase_done", w.done, phase_done);
			end
		end
		out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 26);
	end

	initial begin
		int n, k, cur, eff_dur, rounds;

		// Directed plan
		// ticks before any start take the idle path
		plan.push_back(fixed_row(819200, 0, 819200, 0, 1'b0));
		plan.push_back(fixed_row(-819200, 0, -819200, 0, 1'b0));
		plan.push_back(fixed_row(-1, 0, -1, 0, 1'b0));
		plan.push_back(req_row(REQ_START, 0));
		plan.push_back(fixed_row(0, 0, 0, 0, 1'b0));
		plan.push_back(req_row(REQ_TICK, 600000));
		plan.push_back(req_row(REQ_TICK, -700000));
		// zero duration acts as one, zero half range adds the raw step
		plan.push_back(cfg_row(CFG_DURATION, 0));
		plan.push_back(cfg_row(CFG_WRAP_HALF, 0));
		plan.push_back(cfg_row(CFG_POS_LIMIT, 0));
		plan.push_back(req_row(REQ_START, -819200));
		plan.push_back(req_row(REQ_TICK, 819200));
		plan.push_back(req_row(REQ_TICK, 100));
		// tick after the sweep has completed
		plan.push_back(fixed_row(5, 0, 0, 0, 1'b1));
		// reversed direction with the registers at their extremes
		plan.push_back(cfg_row(CFG_REVERSE, 1));
		plan.push_back(cfg_row(CFG_GAIN, 1048575));
		plan.push_back(cfg_row(CFG_VEL_LIMIT, 3276800));
		plan.push_back(cfg_row(CFG_SWEEP, -823550));
		plan.push_back(cfg_row(CFG_FF_SCALE, 3276800));
		plan.push_back(cfg_row(CFG_DURATION, 3));
		plan.push_back(cfg_row(CFG_WRAP_HALF, 65536));
		plan.push_back(cfg_row(CFG_POS_LIMIT, 819200));
		plan.push_back(req_row(REQ_START, 12345));
		plan.push_back(req_row(REQ_TICK, -819200));
		plan.push_back(req_row(REQ_TICK, 819200));
		plan.push_back(req_row(REQ_TICK, 0));
		plan.push_back(req_row(REQ_TICK, -1));
		// the other extremes, then a restart in the middle of a sweep
		plan.push_back(cfg_row(CFG_VEL_LIMIT, 0));
		plan.push_back(cfg_row(CFG_GAIN, 0));
		plan.push_back(cfg_row(CFG_SWEEP, 823550));
		plan.push_back(cfg_row(CFG_FF_SCALE, -3276800));
		plan.push_back(cfg_row(CFG_REVERSE, 0));
		plan.push_back(cfg_row(CFG_DURATION, 65535));
		plan.push_back(cfg_row(CFG_WRAP_HALF, 819200));
		plan.push_back(cfg_row(CFG_POS_LIMIT, 409600));
		plan.push_back(req_row(REQ_START, 819200));
		plan.push_back(req_row(REQ_TICK, -819200));
		plan.push_back(req_row(REQ_TICK, 700000));
		plan.push_back(req_row(REQ_START, -5));
		plan.push_back(req_row(REQ_TICK, 40000));

		// Reset
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Walk the directed plan
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				wait_drained();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_req(plan[i].req, plan[i].meas, plan[i].typed, plan[i].want);
			end
		end

		// Random sweeps: mostly well-formed, with noise, restarts and idle ticks
		while (sent < RAND_ITEMS) begin
			wait_drained();
			shuffle_settings();
			eff_dur = (dur_r == 0) ? 1 : int'(dur_r);
			rounds = $urandom_range(1, 4);
			repeat (rounds) begin
				if ($urandom_range(0, 5) == 0)
					repeat ($urandom_range(1, 3)) send_req(REQ_TICK, any_meas(), 1'b0, '0);
				cur = any_meas();
				send_req(REQ_START, cur, 1'b0, '0);
				n = (eff_dur <= 24) ? eff_dur + $urandom_range(0, 4) : $urandom_range(4, 24);
				for (k = 0; k < n; k++) begin
					case ($urandom_range(0, 29))
						0: send_req(REQ_START, cur, 1'b0, '0);
						1, 2: cur = any_meas();
						default: cur = walk_meas(cur);
					endcase
					send_req(REQ_TICK, cur, 1'b0, '0);
				end
				// pause the sender until all results are back
				if ($urandom_range(0, 3) == 0)
					wait_drained();
			end
		end

		wait_drained();
		repeat (TAIL) @(posedge clk);
		if (mismatches == 0 && motion_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
